// File: src/sss_pkg.sv
// sample set statistics: shared constants, payload types and sequencer states
package sss_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int SUM_W = 8 + CNT_W;
	localparam int BIT_W = 3;

	typedef struct packed {
		logic [7:0] sample;
		logic       last;
	} in_t;

	typedef struct packed {
		logic [7:0] maximum;
		logic [7:0] minimum;
		logic [7:0] mean;
		logic [7:0] median;
		logic [6:0] sample_count;
		logic       overflow;
	} out_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_SCAN,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// File: src/sss_if.sv
// valid/ready channel interfaces for samples and results
interface sss_in_if;
	logic          valid;
	logic          ready;
	sss_pkg::in_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sss_out_if;
	logic          valid;
	logic          ready;
	sss_pkg::out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/sample_set_statistics_unit.sv
// sample set statistics: load, rank selection of the median, mean division
//
//  channel  | dir | payload                                              | request
//  samples  | in  | sample[8], last[1]                                   | one sample
//  results  | out | maximum, minimum, mean, median[8], sample_count[7],  | one set
//           |     | overflow[1]                                          |
//
// samples are accepted back to back in the load state; after the marked sample
// the set runs start, scan and division: the single comparator scans
// the store once per median bit through its one read port, two ranks of 8 bits
// the mean comes from an 8-step shift/subtract division
// reset clears count, sum, flags and sequencer; the store is never cleared
// a waiting result does not block loading; a finished set waits in its last
// state until the result register is free
module sample_set_statistics_unit (
	input  logic             clk,
	input  logic             arst_n,
	sss_in_if.sink           samples,
	sss_out_if.source        results
);

	sss_pkg::state_t state_q, state_d;

	logic [7:0]                 mem [sss_pkg::MAX_SAMPLES];
	logic [sss_pkg::CNT_W-1:0]  count_q;
	logic [sss_pkg::SUM_W-1:0]  sum_q;
	logic                       drop_q;
	logic [7:0]                 max_q, min_q;

	logic [sss_pkg::CNT_W-1:0]  idx_q, cnt_q, rank_q;
	logic                       rd_vld_q;
	logic [7:0]                 rd_data_q;
	logic [sss_pkg::BIT_W-1:0]  bit_q;
	logic [7:0]                 res_q, sel0_q, median_q;
	logic                       pass_q;

	logic [sss_pkg::SUM_W-1:0]  rem_q;
	logic [7:0]                 quo_q;
	logic [sss_pkg::BIT_W-1:0]  dbit_q;

	sss_pkg::out_t              out_data_q;
	logic                       out_valid_q;

	logic                       accept, store_ok, scan_end, out_load, le;
	logic [7:0]                 thr, res_new;
	logic [8:0]                 med_sum;
	logic [sss_pkg::SUM_W-1:0]  div_sub;
	logic                       div_ge;

	assign accept   = samples.valid && samples.ready;
	assign store_ok = count_q < sss_pkg::CNT_W'(sss_pkg::MAX_SAMPLES);
	assign scan_end = (idx_q == count_q) && !rd_vld_q;
	assign thr      = res_q | ((8'd1 << bit_q) - 8'd1);
	assign le       = rd_data_q <= thr;
	assign res_new  = (cnt_q > rank_q) ? res_q : (res_q | (8'd1 << bit_q));
	assign med_sum  = {1'b0, sel0_q} + {1'b0, res_new};
	assign div_sub  = sss_pkg::SUM_W'(count_q) << dbit_q;
	assign div_ge   = rem_q >= div_sub;
	assign out_load = (state_q == sss_pkg::ST_DONE) && (!out_valid_q || results.ready);

	always_comb begin
		state_d = state_q;
		samples.ready = 1'b0;
		unique case (state_q)
			sss_pkg::ST_LOAD: begin
				samples.ready = 1'b1;
				if (samples.valid && samples.data.last) begin
					state_d = sss_pkg::ST_START;
				end
			end
			sss_pkg::ST_START: state_d = sss_pkg::ST_SCAN;
			sss_pkg::ST_SCAN: begin
				if (scan_end && bit_q == '0 && pass_q) begin
					state_d = sss_pkg::ST_DIV;
				end
			end
			sss_pkg::ST_DIV: begin
				if (dbit_q == '0) begin
					state_d = sss_pkg::ST_DONE;
				end
			end
			sss_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = sss_pkg::ST_LOAD;
				end
			end
			default: state_d = sss_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sss_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// sample store
	always_ff @(posedge clk) begin
		if (accept && store_ok) begin
			mem[count_q[sss_pkg::ADDR_W-1:0]] <= samples.data.sample;
		end
		rd_data_q <= mem[idx_q[sss_pkg::ADDR_W-1:0]];
	end

	// load phase accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
		end else if (out_load) begin
			count_q <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
		end else if (accept) begin
			if (store_ok) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + sss_pkg::SUM_W'(samples.data.sample);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store_ok) begin
			if (count_q == '0 || samples.data.sample > max_q) begin
				max_q <= samples.data.sample;
			end
			if (count_q == '0 || samples.data.sample < min_q) begin
				min_q <= samples.data.sample;
			end
		end
	end

	// median: bitwise rank selection, one store entry compared per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
			idx_q    <= '0;
			cnt_q    <= '0;
			bit_q    <= '0;
			pass_q   <= 1'b0;
			res_q    <= '0;
			rank_q   <= '0;
			sel0_q   <= '0;
			median_q <= '0;
		end else if (state_q == sss_pkg::ST_START) begin
			rd_vld_q <= 1'b0;
			idx_q    <= '0;
			cnt_q    <= '0;
			bit_q    <= sss_pkg::BIT_W'(7);
			pass_q   <= 1'b0;
			res_q    <= '0;
			rank_q   <= (count_q - 1'b1) >> 1;
		end else if (state_q == sss_pkg::ST_SCAN) begin
			if (scan_end) begin
				idx_q <= '0;
				cnt_q <= '0;
				if (bit_q == '0) begin
					res_q  <= '0;
					bit_q  <= sss_pkg::BIT_W'(7);
					pass_q <= 1'b1;
					rank_q <= count_q >> 1;
					if (pass_q) begin
						median_q <= med_sum[8:1];
					end else begin
						sel0_q <= res_new;
					end
				end else begin
					res_q <= res_new;
					bit_q <= bit_q - 1'b1;
				end
				rd_vld_q <= 1'b0;
			end else begin
				rd_vld_q <= idx_q != count_q;
				if (idx_q != count_q) begin
					idx_q <= idx_q + 1'b1;
				end
				if (rd_vld_q && le) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// mean: restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbit_q <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (state_q == sss_pkg::ST_SCAN) begin
			rem_q  <= sum_q;
			quo_q  <= '0;
			dbit_q <= sss_pkg::BIT_W'(7);
		end else if (state_q == sss_pkg::ST_DIV) begin
			if (div_ge) begin
				rem_q <= rem_q - div_sub;
				quo_q <= quo_q | (8'd1 << dbit_q);
			end
			dbit_q <= dbit_q - 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.maximum      <= max_q;
			out_data_q.minimum      <= min_q;
			out_data_q.mean         <= quo_q;
			out_data_q.median       <= median_q;
			out_data_q.sample_count <= 7'(count_q);
			out_data_q.overflow     <= drop_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

endmodule

// File: tb/testbench.sv
// testbench for the sample set statistics unit: directed and random sets against a predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD = 4000;
	localparam int DRAIN_CYCLES = 1200;
	localparam int PHASE_SAMPLES = 100;
	localparam int N_ROWS = 16;

	typedef struct packed {
		logic [7:0]    sample;
		logic          last;
		logic          typed;
		sss_pkg::out_t want;
	} row_t;

	row_t directed_rows [N_ROWS] = '{
		'{8'd0,   1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 7'd1, 1'b0}},
		'{8'd255, 1'b1, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255, 7'd1, 1'b0}},
		'{8'd255, 1'b0, 1'b0, '0},
		'{8'd0,   1'b1, 1'b1, '{8'd255, 8'd0, 8'd127, 8'd127, 7'd2, 1'b0}},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd255, 1'b0, 1'b0, '0},
		'{8'd128, 1'b1, 1'b1, '{8'd255, 8'd0, 8'd127, 8'd128, 7'd3, 1'b0}},
		'{8'd1,   1'b0, 1'b0, '0},
		'{8'd2,   1'b0, 1'b0, '0},
		'{8'd3,   1'b0, 1'b0, '0},
		'{8'd4,   1'b1, 1'b0, '0},
		'{8'd200, 1'b0, 1'b0, '0},
		'{8'd200, 1'b0, 1'b0, '0},
		'{8'd200, 1'b1, 1'b1, '{8'd200, 8'd200, 8'd200, 8'd200, 7'd3, 1'b0}},
		'{8'd170, 1'b0, 1'b0, '0},
		'{8'd85,  1'b1, 1'b1, '{8'd170, 8'd85, 8'd127, 8'd127, 7'd2, 1'b0}}
	};

	logic clk = 1'b0;
	logic arst_n;

	sss_in_if samples_if();
	sss_out_if results_if();

	sample_set_statistics_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if)
	);

	int err_count = 0;
	int samples_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	sss_pkg::out_t stats_due [$];
	logic [7:0] held_samples [$];
	int unsigned held_sum = 0;
	logic held_dropped = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic sss_pkg::out_t set_statistics();
		logic [7:0] ranked [$];
		logic [7:0] v;
		int n;
		int j;
		int mid;
		int med;
		sss_pkg::out_t res;
		ranked = held_samples;
		n = ranked.size();
		for (int i = 1; i < n; i++) begin
			v = ranked[i];
			j = i;
			while (j > 0 && ranked[j - 1] < v) begin
				ranked[j] = ranked[j - 1];
				j--;
			end
			ranked[j] = v;
		end
		mid = n / 2;
		if (n % 2 != 0) begin
			med = ranked[mid];
		end else begin
			med = (int'(ranked[mid - 1]) + int'(ranked[mid])) / 2;
		end
		res.maximum = ranked[0];
		res.minimum = ranked[n - 1];
		res.mean = 8'(held_sum / n);
		res.median = 8'(med);
		res.sample_count = 7'(n);
		res.overflow = held_dropped;
		return res;
	endfunction

	task automatic record_sample(sss_pkg::in_t d, logic typed, sss_pkg::out_t want);
		if (held_samples.size() < sss_pkg::MAX_SAMPLES) begin
			held_samples.push_back(d.sample);
			held_sum += d.sample;
		end else begin
			held_dropped = 1'b1;
		end
		if (d.last) begin
			stats_due.push_back(typed ? want : set_statistics());
			held_samples.delete();
			held_sum = 0;
			held_dropped = 1'b0;
		end
	endtask

	task automatic offer_sample(sss_pkg::in_t d, logic typed, sss_pkg::out_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.data <= d;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		samples_sent++;
		record_sample(d, typed, want);
	endtask

	task automatic offer_set(int n);
		sss_pkg::in_t d;
		int style;
		logic [7:0] base;
		style = $urandom_range(3);
		base = 8'($urandom);
		for (int i = 0; i < n; i++) begin
			unique case (style)
				0: d.sample = 8'($urandom);
				1: d.sample = base;
				2: d.sample = $urandom_range(1) ? 8'd255 : 8'd0;
				default: d.sample = base[7] ? 8'($urandom_range(250, 255))
					: 8'($urandom_range(0, 5));
			endcase
			d.last = (i == n - 1);
			offer_sample(d, 1'b0, '0);
		end
	endtask

	function automatic int pick_set_size();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(1, 8);
		if (r < 92) return $urandom_range(9, 24);
		if (r < 96) return sss_pkg::MAX_SAMPLES;
		return $urandom_range(sss_pkg::MAX_SAMPLES + 1, sss_pkg::MAX_SAMPLES + 6);
	endfunction

	task automatic wait_drained();
		samples_if.valid <= 1'b0;
		do @(posedge clk); while (stats_due.size() != 0);
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want) begin
			flag_error($sformatf("%s: got %0d, want %0d", name, got, want));
		end
	endtask

	task automatic check_result(sss_pkg::out_t got);
		sss_pkg::out_t want;
		if (stats_due.size() == 0) begin
			flag_error($sformatf("result with nothing pending: %h", got));
			return;
		end
		want = stats_due.pop_front();
		check_field("maximum", got.maximum, want.maximum);
		check_field("minimum", got.minimum, want.minimum);
		check_field("mean", got.mean, want.mean);
		check_field("median", got.median, want.median);
		check_field("sample_count", 8'(got.sample_count), 8'(want.sample_count));
		check_field("overflow", 8'(got.overflow), 8'(want.overflow));
	endtask

	// result side: checks each accepted request, then decides ready for the next cycle
	initial begin
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && results_if.valid && results_if.ready) begin
				check_result(results_if.data);
			end
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		sss_pkg::in_t d;
		int goal;
		arst_n <= 1'b0;
		samples_if.valid <= 1'b0;
		samples_if.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			d.sample = directed_rows[i].sample;
			d.last = directed_rows[i].last;
			offer_sample(d, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int p = 0; p < 4; p++) begin
			unique case (p)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 66;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 66;
				end
				default: begin
					send_idle_pct = 36;
					stall_pct = 36;
				end
			endcase
			wait_drained();
			// long result hold-off while samples keep coming
			if (p == 2) hold_seq++;
			goal = samples_sent + PHASE_SAMPLES;
			if (p == 0) begin
				offer_set(sss_pkg::MAX_SAMPLES);
				offer_set(sss_pkg::MAX_SAMPLES + 2);
			end
			while (samples_sent < goal) offer_set(pick_set_size());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout waiting for handshakes");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
src/sss_pkg.sv
src/sss_if.sv
src/sample_set_statistics_unit.sv
tb/testbench.sv
